[rtl/core/xcsv_pkg.sv]
// Shared types and constants for the sentence checksum validator.
package xcsv_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam logic [7:0] RESET_TYPE_FIRST  = 8'd65;
    localparam logic [7:0] RESET_TYPE_SECOND = 8'd68;
    localparam logic [4:0] RESET_EXP_FIELDS  = 5'd5;

    localparam logic [1:0] REG_TYPE_FIRST  = 2'd0;
    localparam logic [1:0] REG_TYPE_SECOND = 2'd1;
    localparam logic [1:0] REG_EXP_FIELDS  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_DOLLAR   = 3'd1,
        ST_NO_STAR     = 3'd2,
        ST_BAD_TEXT    = 3'd3,
        ST_MISMATCH    = 3'd4,
        ST_WRONG_TYPE  = 3'd5,
        ST_WRONG_COUNT = 3'd6
    } t_status;

    // Summary of one finished line, handed from the parser to the verdict stage.
    typedef struct packed {
        logic       no_dollar;
        logic       star_seen;
        logic       hex_bad;
        logic       hex_over;
        logic [7:0] hex_value;
        logic [7:0] xor_star;
        logic       prefix_ok;
        logic [7:0] commas;
    } t_line;

endpackage

[rtl/core/xcsv_front.sv]
// Byte parser: tracks line phase, XOR, checksum digits and commas per line.
module xcsv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_type_first,
    input  logic [7:0]           i_type_second,
    input  logic                 i_q_full,
    output logic                 o_push,
    output xcsv_pkg::t_line      o_line
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_PAY,
        PH_HEX,
        PH_TRAIL,
        PH_SKIP
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_running_xor, n_running_xor;
    logic [7:0]  r_xor_star,    n_xor_star;
    logic        r_star_seen,   n_star_seen;
    logic [7:0]  r_hex_value,   n_hex_value;
    logic        r_hex_digits,  n_hex_digits;
    logic        r_hex_over,    n_hex_over;
    logic        r_hex_bad,     n_hex_bad;
    logic [1:0]  r_pos,         n_pos;
    logic        r_prefix,      n_prefix;
    logic [7:0]  r_commas,      n_commas;
    logic [7:0]  r_commas_star, n_commas_star;
    logic        r_prefix_star, n_prefix_star;

    logic        accept;
    logic        is_nl;
    logic        is_ws;
    logic [4:0]  nib;
    logic [7:0]  want;
    logic        bad_eff;

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_nl   = i_byte == xcsv_pkg::CH_NEWLINE;
    assign is_ws   = i_byte == 8'd9 || i_byte == 8'd11 || i_byte == 8'd12 ||
                     i_byte == 8'd13 || i_byte == 8'd32;
    assign nib     = hex_nibble(i_byte);
    assign want    = (r_pos == 2'd0) ? i_type_first :
                     (r_pos == 2'd1) ? i_type_second : xcsv_pkg::CH_COMMA;

    assign o_push             = accept && is_nl;
    assign o_line.no_dollar   = r_phase == PH_LEAD || r_phase == PH_SKIP;
    assign o_line.star_seen   = r_star_seen;
    assign o_line.hex_bad     = r_hex_bad || !r_hex_digits;
    assign o_line.hex_over    = r_hex_over;
    assign o_line.hex_value   = r_hex_value;
    assign o_line.xor_star    = r_xor_star;
    assign o_line.prefix_ok   = r_prefix_star;
    assign o_line.commas      = r_commas_star;

    always_comb begin
        n_phase       = r_phase;
        n_running_xor = r_running_xor;
        n_xor_star    = r_xor_star;
        n_star_seen   = r_star_seen;
        n_hex_value   = r_hex_value;
        n_hex_digits  = r_hex_digits;
        n_hex_over    = r_hex_over;
        n_hex_bad     = r_hex_bad;
        n_pos         = r_pos;
        n_prefix      = r_prefix;
        n_commas      = r_commas;
        n_commas_star = r_commas_star;
        n_prefix_star = r_prefix_star;
        bad_eff       = 1'b0;
        if (accept) begin
            if (is_nl) begin
                n_phase       = PH_LEAD;
                n_running_xor = 8'd0;
                n_xor_star    = 8'd0;
                n_star_seen   = 1'b0;
                n_hex_value   = 8'd0;
                n_hex_digits  = 1'b0;
                n_hex_over    = 1'b0;
                n_hex_bad     = 1'b0;
                n_pos         = 2'd0;
                n_prefix      = 1'b1;
                n_commas      = 8'd0;
                n_commas_star = 8'd0;
                n_prefix_star = 1'b0;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (i_byte == xcsv_pkg::CH_DOLLAR) begin
                            n_phase = PH_PAY;
                        end else if (!is_ws) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_PAY, PH_HEX, PH_TRAIL: begin
                        if (i_byte == xcsv_pkg::CH_STAR) begin
                            n_xor_star    = r_running_xor;
                            n_commas_star = r_commas;
                            n_prefix_star = r_pos == 2'd3 && r_prefix;
                            n_star_seen   = 1'b1;
                            n_hex_value   = 8'd0;
                            n_hex_digits  = 1'b0;
                            n_hex_over    = 1'b0;
                            n_hex_bad     = 1'b0;
                            n_phase       = PH_HEX;
                        end else if (r_phase != PH_PAY) begin
                            if (is_ws) begin
                                n_phase = PH_TRAIL;
                            end else begin
                                // text after trailing blanks spoils the checksum
                                bad_eff = r_hex_bad || r_phase == PH_TRAIL || !nib[4];
                                n_phase = PH_HEX;
                                if (bad_eff) begin
                                    n_hex_bad = 1'b1;
                                end else begin
                                    n_hex_digits = 1'b1;
                                    if (r_hex_value > 8'd15) begin
                                        n_hex_value = 8'hFF;
                                        n_hex_over  = 1'b1;
                                    end else begin
                                        n_hex_value = {r_hex_value[3:0], nib[3:0]};
                                    end
                                end
                            end
                        end
                        n_running_xor = r_running_xor ^ i_byte;
                        if (r_pos != 2'd3) begin
                            if (i_byte != want) begin
                                n_prefix = 1'b0;
                            end
                            n_pos = r_pos + 2'd1;
                        end else if (i_byte == xcsv_pkg::CH_COMMA && r_commas != 8'hFF) begin
                            n_commas = r_commas + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEAD;
            r_running_xor <= 8'd0;
            r_xor_star    <= 8'd0;
            r_star_seen   <= 1'b0;
            r_hex_value   <= 8'd0;
            r_hex_digits  <= 1'b0;
            r_hex_over    <= 1'b0;
            r_hex_bad     <= 1'b0;
            r_pos         <= 2'd0;
            r_prefix      <= 1'b1;
            r_commas      <= 8'd0;
            r_commas_star <= 8'd0;
            r_prefix_star <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_running_xor <= n_running_xor;
            r_xor_star    <= n_xor_star;
            r_star_seen   <= n_star_seen;
            r_hex_value   <= n_hex_value;
            r_hex_digits  <= n_hex_digits;
            r_hex_over    <= n_hex_over;
            r_hex_bad     <= n_hex_bad;
            r_pos         <= n_pos;
            r_prefix      <= n_prefix;
            r_commas      <= n_commas;
            r_commas_star <= n_commas_star;
            r_prefix_star <= n_prefix_star;
        end
    end

`ifndef SYNTHESIS
    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_phase == PH_LEAD && !r_star_seen && r_running_xor == 8'd0)
        else $error("line state not cleared after newline");
    a_over_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_over |-> r_hex_value == 8'hFF && r_hex_digits)
        else $error("checksum overflow without saturation");
    a_star_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEX || r_phase == PH_TRAIL) |-> r_star_seen)
        else $error("checksum phase without star");
`endif

endmodule

[rtl/core/xcsv_queue.sv]
// Short FIFO of finished line summaries between parser and verdict stage.
module xcsv_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xcsv_pkg::t_line      i_line,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output xcsv_pkg::t_line      o_line
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    xcsv_pkg::t_line r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_line  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

[rtl/core/xcsv_back.sv]
// Verdict stage: turns a line summary into status and sums, with output register.
module xcsv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  xcsv_pkg::t_line      i_line,
    output logic                 o_pop,
    input  logic [4:0]           i_exp_fields,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [7:0]           o_computed_sum,
    output logic [7:0]           o_received_sum,
    output logic [7:0]           o_field_count
);

    logic              r_valid;
    xcsv_pkg::t_status r_status, n_status;
    logic [7:0]        r_cs, n_cs;
    logic [7:0]        r_rs, n_rs;
    logic [7:0]        r_fc, n_fc;
    logic [7:0]        fc_all;

    assign o_pop  = i_q_valid && (!r_valid || i_ready);
    assign fc_all = (i_line.commas == 8'hFF) ? 8'hFF : i_line.commas + 8'd1;

    always_comb begin
        n_status = xcsv_pkg::ST_OK;
        n_cs     = 8'd0;
        n_rs     = 8'd0;
        n_fc     = 8'd0;
        if (i_line.no_dollar) begin
            n_status = xcsv_pkg::ST_NO_DOLLAR;
        end else if (!i_line.star_seen) begin
            n_status = xcsv_pkg::ST_NO_STAR;
        end else begin
            n_cs = i_line.xor_star;
            if (i_line.hex_bad) begin
                n_status = xcsv_pkg::ST_BAD_TEXT;
            end else begin
                n_rs = i_line.hex_value;
                if (i_line.hex_over || i_line.hex_value != i_line.xor_star) begin
                    n_status = xcsv_pkg::ST_MISMATCH;
                end else if (!i_line.prefix_ok) begin
                    n_status = xcsv_pkg::ST_WRONG_TYPE;
                end else begin
                    n_fc     = fc_all;
                    n_status = (fc_all == {3'b000, i_exp_fields}) ?
                               xcsv_pkg::ST_OK : xcsv_pkg::ST_WRONG_COUNT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_cs     <= n_cs;
            r_rs     <= n_rs;
            r_fc     <= n_fc;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_computed_sum = r_cs;
    assign o_received_sum = r_rs;
    assign o_field_count  = r_fc;

`ifndef SYNTHESIS
    a_ok_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == xcsv_pkg::ST_OK) |-> r_cs == r_rs && r_fc != 8'd0)
        else $error("ok verdict with unequal sums");
    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == xcsv_pkg::ST_NO_DOLLAR ||
                     r_status == xcsv_pkg::ST_NO_STAR)) |-> r_cs == 8'd0 && r_rs == 8'd0)
        else $error("sums reported for line without star");
    a_fc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != xcsv_pkg::ST_OK &&
         r_status != xcsv_pkg::ST_WRONG_COUNT) |-> r_fc == 8'd0)
        else $error("field count reported for failed line");
`endif

endmodule

[rtl/core/xor_checked_sentence_validator.sv]
// Top level of the sentence checksum validator with its register port.
//
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte): one ASCII byte per
// transfer; the byte 10 ends a line. Every newline yields exactly one
// result transfer on the output channel (o_res_valid / i_res_ready) carrying
// status, computed XOR, parsed checksum and field count; other bytes yield
// nothing. A byte is taken every cycle while the line queue has room.
// A newline's line summary passes through the line queue and then the verdict
// register before o_res_valid. Throughput is one byte per cycle while the line
// queue has room, as the parser updates its line state on every accepted byte.
// When the receiver stalls, results collect in the output register and the
// QUEUE_DEPTH-entry line queue; o_rx_ready drops only once the queue is full.
// Reset (synchronous, active low) clears the line state, empties the queue and
// loads the registers with type 'A','D' and 5 expected fields.
// Registers (by paddr[3:2]): 0 first type byte, 1 second type byte, 2 expected field count.
module xor_checked_sentence_validator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum,
    output logic [7:0]  o_field_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]      r_type_first;
    logic [7:0]      r_type_second;
    logic [4:0]      r_exp_fields;
    logic            wr_en;
    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    xcsv_pkg::t_line push_line;
    xcsv_pkg::t_line pop_line;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_first  <= xcsv_pkg::RESET_TYPE_FIRST;
            r_type_second <= xcsv_pkg::RESET_TYPE_SECOND;
            r_exp_fields  <= xcsv_pkg::RESET_EXP_FIELDS;
        end else if (wr_en) begin
            case (paddr[3:2])
                xcsv_pkg::REG_TYPE_FIRST:  r_type_first  <= pwdata[7:0];
                xcsv_pkg::REG_TYPE_SECOND: r_type_second <= pwdata[7:0];
                xcsv_pkg::REG_EXP_FIELDS:  r_exp_fields  <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            xcsv_pkg::REG_TYPE_FIRST:  prdata = {24'd0, r_type_first};
            xcsv_pkg::REG_TYPE_SECOND: prdata = {24'd0, r_type_second};
            xcsv_pkg::REG_EXP_FIELDS:  prdata = {27'd0, r_exp_fields};
            default:                   prdata = 32'd0;
        endcase
    end

    xcsv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_rx_valid),
        .o_ready       (o_rx_ready),
        .i_byte        (i_rx_byte),
        .i_type_first  (r_type_first),
        .i_type_second (r_type_second),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_line        (push_line)
    );

    xcsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_line  (push_line),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_line  (pop_line)
    );

    xcsv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_line         (pop_line),
        .o_pop          (pop),
        .i_exp_fields   (r_exp_fields),
        .o_valid        (o_res_valid),
        .i_ready        (i_res_ready),
        .o_status       (o_status),
        .o_computed_sum (o_computed_sum),
        .o_received_sum (o_received_sum),
        .o_field_count  (o_field_count)
    );

endmodule
